### src/crc_with_nibble_xor_checksum_unit_defines.svh
// Assertion macros for the CRC / nibble-checksum unit.
// Clock i_clk and active-low reset i_rst_n are assumed in the using scope.
`ifndef CRC_WITH_NIBBLE_XOR_CHECKSUM_UNIT_DEFINES_SVH
`define CRC_WITH_NIBBLE_XOR_CHECKSUM_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CNXC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("cnxc same-cycle check failed");

// Next-cycle implication.
`define CNXC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("cnxc next-cycle check failed");

`endif

### src/cnxc_pkg.sv
// Shared constants, types and CRC/checksum functions for the CRC unit.
// No dependencies.
package cnxc_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned NibW  = 4;
    localparam int unsigned SelW  = 2;

    // Generator select codes
    localparam logic [SelW-1:0] SelCrc3 = 2'd0;
    localparam logic [SelW-1:0] SelCrc4 = 2'd1;
    localparam logic [SelW-1:0] SelCrc8 = 2'd2;
    localparam logic [SelW-1:0] SelRsvd = 2'd3;

    // Generators without the implicit top term, and remainder masks
    localparam logic [ByteW-1:0] Poly3 = 8'h05;
    localparam logic [ByteW-1:0] Poly4 = 8'h06;
    localparam logic [ByteW-1:0] Poly8 = 8'h35;
    localparam logic [ByteW-1:0] Mask3 = 8'h07;
    localparam logic [ByteW-1:0] Mask4 = 8'h0F;
    localparam logic [ByteW-1:0] Mask8 = 8'hFF;

    // ASCII range limits
    localparam logic [ByteW-1:0] AsciiDig0 = 8'h30;
    localparam logic [ByteW-1:0] AsciiDig9 = 8'h39;
    localparam logic [ByteW-1:0] AsciiUpA  = 8'h41;
    localparam logic [ByteW-1:0] AsciiUpZ  = 8'h5A;
    localparam logic [ByteW-1:0] AsciiLoA  = 8'h61;
    localparam logic [ByteW-1:0] AsciiLoZ  = 8'h7A;

    typedef struct packed {
        logic             fire;
        logic [ByteW-1:0] data_byte;
        logic             last;
    } t_step;

    typedef struct packed {
        logic [ByteW-1:0] rem;
        logic [NibW-1:0]  par;
    } t_acc;

    typedef struct packed {
        logic [ByteW-1:0] crc_value;
        logic [NibW-1:0]  chk_nibble;
    } t_result;

    function automatic logic [ByteW-1:0] sel_mask(input logic [SelW-1:0] sel);
        logic [ByteW-1:0] m;
        unique case (sel) inside
            SelCrc3:          m = Mask3;
            SelCrc4:          m = Mask4;
            SelCrc8, SelRsvd: m = Mask8;
            default:          m = Mask8;
        endcase
        return m;
    endfunction

    function automatic logic [ByteW-1:0] sel_poly(input logic [SelW-1:0] sel);
        logic [ByteW-1:0] p;
        unique case (sel) inside
            SelCrc3:          p = Poly3;
            SelCrc4:          p = Poly4;
            SelCrc8, SelRsvd: p = Poly8;
            default:          p = Poly8;
        endcase
        return p;
    endfunction

    function automatic logic top_bit(input logic [ByteW-1:0] rem,
                                     input logic [SelW-1:0]  sel);
        logic t;
        unique case (sel) inside
            SelCrc3:          t = rem[2];
            SelCrc4:          t = rem[3];
            SelCrc8, SelRsvd: t = rem[7];
            default:          t = rem[7];
        endcase
        return t;
    endfunction

    function automatic logic is_alnum(input logic [ByteW-1:0] c);
        return ((c >= AsciiDig0) && (c <= AsciiDig9)) ||
               ((c >= AsciiUpA)  && (c <= AsciiUpZ))  ||
               ((c >= AsciiLoA)  && (c <= AsciiLoZ));
    endfunction

    // Eight MSB-first division steps, remainder right-aligned at the width of sel
    function automatic logic [ByteW-1:0] crc_byte(input logic [ByteW-1:0] rem_in,
                                                  input logic [ByteW-1:0] b,
                                                  input logic [SelW-1:0]  sel);
        logic [ByteW-1:0] mask;
        logic [ByteW-1:0] poly;
        logic [ByteW-1:0] rem;
        logic [ByteW-1:0] bits;
        logic             fb;
        mask = sel_mask(sel);
        poly = sel_poly(sel);
        rem  = rem_in & mask;
        bits = b;
        for (int k = 0; k < ByteW; k++) begin
            fb   = top_bit(rem, sel) ^ bits[ByteW-1];
            rem  = (rem << 1) & mask;
            bits = bits << 1;
            if (fb) begin
                rem = rem ^ poly;
            end
        end
        return rem;
    endfunction

endpackage

### src/cnxc_in_if.sv
// Input channel: one message byte and its end-of-message flag per item.
// Depends on cnxc_pkg.
interface cnxc_in_if;
    logic                          valid;
    logic                          ready;
    logic [cnxc_pkg::ByteW-1:0]    data_byte;
    logic                          last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

### src/cnxc_out_if.sv
// Result channel: CRC remainder and 4-bit checksum per item.
// Depends on cnxc_pkg.
interface cnxc_out_if;
    logic                          valid;
    logic                          ready;
    logic [cnxc_pkg::ByteW-1:0]    crc_value;
    logic [cnxc_pkg::NibW-1:0]     chk_nibble;

    modport source (output valid, output crc_value, output chk_nibble, input ready);
    modport sink   (input valid, input crc_value, input chk_nibble, output ready);
endinterface

### src/crc_with_nibble_xor_checksum_unit.sv
// Top level: input register, accumulator stage, result register, select register.
// Depends on cnxc_pkg, cnxc_in_if, cnxc_out_if, cnxc_accum and the defines header.
//
//   port      dir   handshake     carries
//   i_in      in    valid/ready   data_byte[7:0], last
//   o_res     out   valid/ready   crc_value[7:0], chk_nibble[3:0]
//   i_cfg_*   in    write enable  crc_select[1:0]
//
// One byte per cycle sustained unless a last byte waits on a stalled result; a result
// passes through the input register, then the result register, after its last byte is taken.
// Synchronous active-low reset clears the accumulators, select and valid flags.
// A stalled result holds the next last byte in the input register, and the input behind it;
// ordinary bytes ahead of it keep flowing into the accumulators while the result waits.
`include "crc_with_nibble_xor_checksum_unit_defines.svh"

module crc_with_nibble_xor_checksum_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cnxc_in_if.sink                       i_in,
    cnxc_out_if.source                    o_res,
    input  logic                          i_cfg_we,
    input  logic [cnxc_pkg::SelW-1:0]     i_cfg_wdata
);

    logic                          r_s1_valid;
    logic [cnxc_pkg::ByteW-1:0]    r_s1_byte;
    logic                          r_s1_last;
    logic                          r_out_valid;
    logic [cnxc_pkg::ByteW-1:0]    r_out_crc;
    logic [cnxc_pkg::NibW-1:0]     r_out_chk;
    logic [cnxc_pkg::SelW-1:0]     r_sel;
    logic [cnxc_pkg::SelW-1:0]     n_sel;

    logic                          out_free;
    logic                          s1_fire;
    logic                          in_fire;
    cnxc_pkg::t_step               step;
    cnxc_pkg::t_result             result;
    cnxc_pkg::t_acc                acc;

    assign out_free    = !r_out_valid || o_res.ready;
    // a byte without last produces nothing, so it never waits on the output
    assign s1_fire     = r_s1_valid && (!r_s1_last || out_free);
    assign i_in.ready  = !r_s1_valid || s1_fire;
    assign in_fire     = i_in.valid && i_in.ready;

    assign step.fire      = s1_fire;
    assign step.data_byte = r_s1_byte;
    assign step.last      = r_s1_last;

    cnxc_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_sel    (r_sel),
        .o_result (result),
        .o_acc    (acc)
    );

    // selector three behaves as CRC-8
    assign n_sel = (i_cfg_wdata == cnxc_pkg::SelRsvd) ? cnxc_pkg::SelCrc8 : i_cfg_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= cnxc_pkg::SelCrc3;
        end else if (i_cfg_we) begin
            r_sel <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_last <= i_in.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            r_out_crc <= result.crc_value;
            r_out_chk <= result.chk_nibble;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.crc_value  = r_out_crc;
    assign o_res.chk_nibble = r_out_chk;

    // A blocked last byte stays in the input register.
    `CNXC_ASSERT_NEXT(a_last_held, r_s1_valid && r_s1_last && !out_free, r_s1_valid && r_s1_last)
    // Accumulators restart from zero after a message closes.
    `CNXC_ASSERT_NEXT(a_acc_cleared, s1_fire && r_s1_last, acc.rem == '0 && acc.par == '0)
    // Only CRC-8 can produce a result with high bits set.
    `CNXC_ASSERT_NOW(a_crc_width, r_out_valid && r_out_crc[7:4] != '0, r_sel == cnxc_pkg::SelCrc8)

endmodule

### src/cnxc_accum.sv
// Running CRC remainder and nibble parity, with the one-byte update logic.
// Depends on cnxc_pkg.
module cnxc_accum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cnxc_pkg::t_step               i_step,
    input  logic [cnxc_pkg::SelW-1:0]     i_sel,
    output cnxc_pkg::t_result             o_result,
    output cnxc_pkg::t_acc                o_acc
);

    logic [cnxc_pkg::ByteW-1:0] r_rem;
    logic [cnxc_pkg::NibW-1:0]  r_par;
    logic [cnxc_pkg::ByteW-1:0] n_rem;
    logic [cnxc_pkg::NibW-1:0]  n_par;
    logic [cnxc_pkg::ByteW-1:0] upd_rem;
    logic [cnxc_pkg::NibW-1:0]  upd_par;
    logic [cnxc_pkg::ByteW-1:0] cur_rem;

    always_comb begin
        // stale high bits drop out if the width changed between messages
        cur_rem = r_rem & cnxc_pkg::sel_mask(i_sel);
        upd_rem = cur_rem;
        upd_par = r_par;
        if (cnxc_pkg::is_alnum(i_step.data_byte)) begin
            upd_rem = cnxc_pkg::crc_byte(cur_rem, i_step.data_byte, i_sel);
            upd_par = r_par ^ i_step.data_byte[7:4] ^ i_step.data_byte[3:0];
        end
    end

    assign o_result.crc_value  = upd_rem;
    assign o_result.chk_nibble = upd_par ^ upd_rem[3:0] ^ upd_rem[7:4];
    assign o_acc.rem = r_rem;
    assign o_acc.par = r_par;

    always_comb begin
        n_rem = r_rem;
        n_par = r_par;
        if (i_step.fire) begin
            if (i_step.last) begin
                n_rem = '0;
                n_par = '0;
            end else begin
                n_rem = upd_rem;
                n_par = upd_par;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_par <= '0;
        end else begin
            r_rem <= n_rem;
            r_par <= n_par;
        end
    end

endmodule
